// ----- rtl/chte_pkg.sv -----
// ----------------------------------------------------------------------------
// chte_pkg
// shared types, codes and the hash mixing function of the chained hash table
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int unsigned BUCKETS_DEF    = 16;
  localparam int unsigned ENTRIES_DEF    = 64;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_PUT    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_NODE,
    S_CHECK,
    S_DONE
  } state_t;

  function automatic logic [31:0] mix_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 20) ^ (h >> 12);
    return t ^ (t >> 7) ^ (t >> 4);
  endfunction

endpackage

// ----- rtl/chte_ram.sv -----
// ----------------------------------------------------------------------------
// chte_ram
// generic simple dual-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/chained_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// key/value table with separate chaining over a fixed node pool
// ----------------------------------------------------------------------------
// walk: S_HEAD reads the head, S_NODE reads the first node, S_CHECK examines
//   nodes up to a match or the chain end; an empty bucket goes S_NODE to S_DONE
// a new transaction is taken only in S_IDLE, after done; each chain step
//   waits on one node-memory read
// reset: synchronous; head valid bits, free mask and count clear;
//   node memory is not cleared, it is only reached through written links
// results cannot be stalled: result is shown for one cycle with done
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int unsigned BUCKETS    = chte_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES    = chte_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = chte_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = chte_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] key_hash,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] data,
  output logic [6:0]  entry_total
);
  import chte_pkg::*;

  // bucket select is a mask, so BUCKETS must be a power of two; not checked here
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned NW = $clog2(ENTRIES);
  // pointer carries one extra bit: top bit set means null
  localparam int unsigned PW = NW + 1;
  localparam int unsigned KB = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  // node word: link, mixed hash, key, value
  localparam int unsigned NODE_W = PW + 32 + KB + VB;
  localparam logic [PW-1:0] NULL_PTR = {1'b1, {NW{1'b0}}};

  state_t state, state_next;

  // request registers
  logic [1:0]    r_kind;
  logic [KB-1:0] r_key;
  logic [31:0]   r_mixed;
  logic [VB-1:0] r_val;
  logic [BW-1:0] r_bucket;
  logic [31:0]   hash_in;

  // walk registers
  logic [NW-1:0]      cur;
  logic [PW-1:0]      prev;
  logic [NODE_W-1:0]  prev_word;
  logic [CW-1:0]      count;
  logic [BUCKETS-1:0] head_valid;
  logic [ENTRIES-1:0] free_mask;

  // result registers and the new-node write held for the done cycle
  logic [1:0]    res_status, res_status_next;
  logic [31:0]   res_data, res_data_next;
  logic          pend_new, pend_new_next;
  logic [NW-1:0] pend_node;

  // memories
  logic              head_we;
  logic [PW-1:0]     head_wdata, head_rdata;
  logic              node_we;
  logic [NW-1:0]     node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;

  chte_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(r_bucket), .wdata(head_wdata),
    .raddr(r_bucket), .rdata(head_rdata)
  );

  chte_ram #(.WIDTH(NODE_W), .DEPTH(ENTRIES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  logic [PW-1:0] n_link;
  logic [31:0]   n_mixed;
  logic [KB-1:0] n_key;
  logic [VB-1:0] n_val;
  assign {n_link, n_mixed, n_key, n_val} = node_rdata;

  // lowest free node, searched over the free mask
  logic [NW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = NW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [PW-1:0] head_ptr;
  logic          head_null;
  logic          match;
  logic          tail;
  logic          accept;
  assign accept    = start && !busy;
  assign hash_in   = mix_hash(key_hash);
  // head memory content is only trusted once that bucket has been written
  assign head_ptr  = head_valid[r_bucket] ? head_rdata : NULL_PTR;
  assign head_null = head_ptr[PW-1];
  assign match     = (n_mixed == r_mixed) && (n_key == r_key);
  assign tail      = n_link[PW-1];
  // first node read comes from the head, later ones follow the link
  assign node_raddr = (state == S_NODE) ? head_ptr[NW-1:0] : n_link[NW-1:0];

  // walk ends on an empty bucket, a match or the last node of the chain
  logic fin;
  logic fin_hit;
  assign fin     = (state == S_NODE && head_null) ||
                   (state == S_CHECK && (match || tail));
  assign fin_hit = (state == S_CHECK) && match;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_HEAD;
      S_HEAD:  state_next = S_NODE;
      S_NODE:  state_next = head_null ? S_DONE : S_CHECK;
      S_CHECK: state_next = (match || tail) ? S_DONE : S_CHECK;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs, memory writes and the result of the walk
  always_comb begin
    busy            = (state != S_IDLE);
    done            = (state == S_DONE);
    head_we         = 1'b0;
    head_wdata      = n_link;
    node_we         = 1'b0;
    node_waddr      = cur;
    node_wdata      = node_rdata;
    res_status_next = ST_MISS;
    res_data_next   = '0;
    pend_new_next   = 1'b0;
    if (state == S_DONE) begin
      // new node of an insert goes in while the result is shown
      node_we    = pend_new;
      node_waddr = pend_node;
      node_wdata = {NULL_PTR, r_mixed, r_key, r_val};
    end else if (fin) begin
      unique case (r_kind)
        KIND_LOOKUP: begin
          if (fin_hit) begin
            res_status_next = ST_FOUND;
            res_data_next   = 32'(n_val);
          end
        end
        KIND_PUT: begin
          if (fin_hit) begin
            // overwrite keeps link, hash and key
            node_we         = 1'b1;
            node_wdata      = {node_rdata[NODE_W-1:VB], r_val};
            res_status_next = ST_FOUND;
          end else if (!free_any) begin
            res_status_next = ST_FULL;
          end else begin
            res_status_next = ST_INSERTED;
            pend_new_next   = 1'b1;
            if (state == S_NODE) begin
              // empty bucket: new node becomes the head
              head_we    = 1'b1;
              head_wdata = {1'b0, free_idx};
            end else begin
              // append behind the tail node just read
              node_we    = 1'b1;
              node_wdata = {1'b0, free_idx, node_rdata[NODE_W-PW-1:0]};
            end
          end
        end
        KIND_REMOVE: begin
          if (fin_hit) begin
            res_status_next = ST_FOUND;
            res_data_next   = 32'(n_val);
            if (prev[PW-1]) begin
              head_we    = 1'b1;
              head_wdata = n_link;
            end else begin
              // predecessor skips the removed node
              node_we    = 1'b1;
              node_waddr = prev[NW-1:0];
              node_wdata = {n_link, prev_word[NODE_W-PW-1:0]};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control state, occupancy and free mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_valid <= '0;
      free_mask  <= '1;
      count      <= '0;
    end else begin
      state <= state_next;
      if (head_we) begin
        head_valid[r_bucket] <= 1'b1;
      end
      if (fin) begin
        unique case (r_kind)
          KIND_PUT: begin
            if (!fin_hit && free_any) begin
              free_mask[free_idx] <= 1'b0;
              count <= count + CW'(1);
            end
          end
          KIND_REMOVE: begin
            if (fin_hit) begin
              free_mask[cur] <= 1'b1;
              if (count != '0) count <= count - CW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload, walk and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind   <= kind;
      r_key    <= key[KB-1:0];
      r_mixed  <= hash_in;
      r_val    <= value[VB-1:0];
      r_bucket <= hash_in[BW-1:0];
      prev     <= NULL_PTR;
    end
    if (state == S_NODE) begin
      cur <= head_ptr[NW-1:0];
    end
    if (state == S_CHECK && !fin) begin
      prev      <= {1'b0, cur};
      prev_word <= node_rdata;
      cur       <= n_link[NW-1:0];
    end
    if (fin) begin
      res_status <= res_status_next;
      res_data   <= res_data_next;
      pend_new   <= pend_new_next;
      pend_node  <= free_idx;
    end
  end

  assign status      = res_status;
  assign data        = res_data;
  assign entry_total = 7'(count);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done);
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_HEAD));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES));
  a_full_match: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(ENTRIES)) == !free_any);

endmodule

// ----- verif/chained_hash_table_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_tb
// drives lookup, put and remove transactions into the hash table engine,
// mirrors the table contents in a behavioral copy and checks every result
// ----------------------------------------------------------------------------
module chained_hash_table_engine_tb;
  import chte_pkg::*;

  localparam int NBKT  = 16;
  localparam int NNODE = 64;
  localparam int NIL   = NNODE;
  localparam int WATCHDOG_LIMIT = 20000;

  // one expected answer of the table
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [6:0]  entry_total;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_LOOKUP;
  logic [31:0] key = '0;
  logic [31:0] key_hash = '0;
  logic [31:0] value = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] data;
  logic [6:0]  entry_total;

  // mirror of the table
  int          mir_head [NBKT];
  logic [31:0] mir_key [NNODE];
  logic [31:0] mir_val [NNODE];
  logic [31:0] mir_mix [NNODE];
  int          mir_link [NNODE];
  bit          mir_free [NNODE];
  int          mir_count;

  answer_t     answer_q[$];
  logic [31:0] key_pool[$];   // keys put so far, to revisit them
  int          send_idle_pct;
  int          errors = 0;
  int          quiet_cycles = 0;

  chained_hash_table_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .key(key),
    .key_hash(key_hash), .value(value), .done(done), .status(status),
    .data(data), .entry_total(entry_total)
  );

  always #2 clk = ~clk;

  // supplemental xor-shift, written out here
  function automatic logic [31:0] spread_hash(logic [31:0] h);
    logic [31:0] t;
    t = h ^ {20'd0, h[31:20]} ^ {12'd0, h[31:12]};
    return t ^ {7'd0, t[31:7]} ^ {4'd0, t[31:4]};
  endfunction

  // apply one request to the mirror and return its answer
  function automatic answer_t table_apply(logic [1:0] k, logic [31:0] ky,
                                          logic [31:0] kh, logic [31:0] v);
    answer_t a;
    logic [31:0] m;
    int b, prev, cur, steps, n;
    m = spread_hash(kh);
    b = m[3:0];
    prev = NIL;
    cur = mir_head[b];
    steps = 0;
    a.status = ST_MISS;
    a.data = '0;
    while (cur < NIL && steps < NNODE) begin
      if (mir_mix[cur] == m && mir_key[cur] == ky) break;
      prev = cur;
      cur = mir_link[cur];
      steps++;
    end
    if (steps >= NNODE) cur = NIL;
    case (k)
      KIND_LOOKUP: begin
        if (cur < NIL) begin
          a.status = ST_FOUND;
          a.data = mir_val[cur];
        end
      end
      KIND_PUT: begin
        if (cur < NIL) begin
          mir_val[cur] = v;
          a.status = ST_FOUND;
        end else begin
          n = NIL;
          for (int i = NNODE - 1; i >= 0; i--) if (mir_free[i]) n = i;
          if (n == NIL) a.status = ST_FULL;
          else begin
            mir_free[n] = 1'b0;
            mir_key[n] = ky;
            mir_val[n] = v;
            mir_mix[n] = m;
            mir_link[n] = NIL;
            if (prev < NIL) mir_link[prev] = n;
            else mir_head[b] = n;
            mir_count++;
            a.status = ST_INSERTED;
          end
        end
      end
      KIND_REMOVE: begin
        if (cur < NIL) begin
          if (prev < NIL) mir_link[prev] = mir_link[cur];
          else mir_head[b] = mir_link[cur];
          a.data = mir_val[cur];
          mir_free[cur] = 1'b1;
          if (mir_count > 0) mir_count--;
          a.status = ST_FOUND;
        end
      end
      default: ;
    endcase
    a.entry_total = mir_count[6:0];
    return a;
  endfunction

  // send one transaction, with a random gap ahead of it
  task automatic send_request(logic [1:0] k, logic [31:0] ky, logic [31:0] kh,
                              logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    key <= ky;
    key_hash <= kh;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge; start drops or carries the next transaction
    answer_q.push_back(table_apply(k, ky, kh, v));
    if (k == KIND_PUT) key_pool.push_back(ky);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // result checker: compares against the oldest expected answer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h total=%0d",
                 $time, status, data, entry_total);
        errors++;
      end else begin
        answer_t e;
        e = answer_q.pop_front();
        if (e.status !== status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (e.data !== data) begin
          $display("%0t: data expected %h actual %h", $time, e.data, data);
          errors++;
        end
        if (e.entry_total !== entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d",
                   $time, e.entry_total, entry_total);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed: empty table, extremes, overwrite, collisions, unused kind
  task automatic test_directed();
    send_request(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_request(KIND_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_request(KIND_PUT, 32'h0, 32'h0, 32'hffff_ffff);
    send_request(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_request(KIND_PUT, 32'h0, 32'h0, 32'h1234_5678);     // overwrite
    send_request(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    // same hash, different keys: one long chain
    send_request(KIND_PUT, 32'h11, 32'h0, 32'haaaa_aaaa);
    send_request(KIND_PUT, 32'h22, 32'h0, 32'h5555_5555);
    send_request(KIND_LOOKUP, 32'h22, 32'h0, 32'h0);
    send_request(KIND_REMOVE, 32'h11, 32'h0, 32'h0);          // mid-chain unlink
    send_request(KIND_LOOKUP, 32'h22, 32'h0, 32'h0);
    send_request(KIND_REMOVE, 32'h0, 32'h0, 32'h0);           // head unlink
    send_request(KIND_LOOKUP, 32'h22, 32'h1, 32'h0);          // same key, other hash
    send_request(2'd3, 32'h22, 32'h0, 32'hdead_beef);         // unused kind
    send_request(KIND_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
  endtask

  // fill the pool to exhaustion, then overwrite and reject
  task automatic test_pool_full();
    for (int i = 0; i < 66; i++)
      send_request(KIND_PUT, 32'h100 + i, $urandom(), $urandom());
    send_request(KIND_PUT, 32'h105, 32'h0, 32'hcafe_f00d);    // fresh hash, full
    send_request(KIND_PUT, 32'h0, 32'h0, 32'h0);
    send_request(KIND_PUT, 32'h22, 32'h0, 32'h7777_7777);     // overwrite when full
    wait_drained();                                            // sender pause
    send_request(KIND_REMOVE, 32'h22, 32'h0, 32'h0);
    send_request(KIND_PUT, 32'hbeef, 32'h3, 32'h9);            // reuses lowest node
  endtask

  // random mix, mostly on known keys; hashes from a small set to collide
  task automatic test_random(int count);
    logic [31:0] ky, kh;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (key_pool.size() != 0 && $urandom_range(99) < 70)
        ky = key_pool[$urandom_range(key_pool.size() - 1)];
      else ky = $urandom();
      kh = ($urandom_range(3) == 0) ? $urandom() : {28'd0, ky[3:0]} ^ {ky[31:28], 28'd0};
      if (r < 2) send_request(2'd3, ky, kh, $urandom());
      else if (r < 40) send_request(KIND_PUT, ky, kh, $urandom());
      else if (r < 70) send_request(KIND_LOOKUP, ky, kh, $urandom());
      else send_request(KIND_REMOVE, ky, kh, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < NBKT; i++) mir_head[i] = NIL;
    for (int i = 0; i < NNODE; i++) begin
      mir_free[i] = 1'b1;
      mir_link[i] = NIL;
    end
    mir_count = 0;
    send_idle_pct = 24;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_random(480);
    send_idle_pct = 68;
    test_random(480);
    send_idle_pct = 0;
    test_random(480);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/chte_pkg.sv
rtl/chte_ram.sv
rtl/chained_hash_table_engine.sv
verif/chained_hash_table_engine_tb.sv
